### rtl/rosel_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosel_pkg
// Shared widths, the rank reset constant and the queue entry type of the rank-order
// selector.
// ----------------------------------------------------------------------------
package rosel_pkg;

    localparam int unsigned SAMPLE_W = 16;
    localparam int unsigned RANK_W   = 6;

    localparam logic [RANK_W-1:0] RANK_RESET = 6'd31;

    // One classified sample on its way from the front to the back.
    typedef struct packed {
        logic                last;
        logic [SAMPLE_W-1:0] sample;
    } t_item;

endpackage

### rtl/rosel_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosel_front
// Accepts sample beats, tags the beat that closes a window and holds the rank
// register.
// ----------------------------------------------------------------------------
module rosel_front #(
    parameter int unsigned WINDOW = 50
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rosel_pkg::SAMPLE_W-1:0]  i_s_tdata,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rosel_pkg::RANK_W-1:0]    i_cfg_data,
    input  logic                            i_full,
    output logic                            o_push,
    output rosel_pkg::t_item                o_item,
    output logic [rosel_pkg::RANK_W-1:0]    o_rank
);
    import rosel_pkg::*;

    localparam int unsigned AW = $clog2(WINDOW);

    logic [AW-1:0]     r_count;
    logic [AW-1:0]     n_count;
    logic [RANK_W-1:0] r_rank;
    logic              last;

    assign o_s_tready  = !i_full;
    assign o_cfg_ready = 1'b1;
    assign o_push      = i_s_tvalid && !i_full;
    assign last        = (r_count == AW'(WINDOW - 1));
    assign o_item.last   = last;
    assign o_item.sample = i_s_tdata;
    assign o_rank      = r_rank;

    always_comb begin
        n_count = r_count;
        if (o_push) begin
            n_count = last ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_rank  <= RANK_RESET;
        end else begin
            r_count <= n_count;
            if (i_cfg_valid) begin
                r_rank <= i_cfg_data;
            end
        end
    end

endmodule

### rtl/rosel_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosel_fifo
// Two-entry queue that lets the front and the back stall independently.
// ----------------------------------------------------------------------------
module rosel_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rosel_pkg::t_item i_item,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output rosel_pkg::t_item o_item
);
    import rosel_pkg::*;

    t_item       r_buf [2];
    logic        r_wr;
    logic        r_rd;
    logic [1:0]  r_fill;

    assign o_full  = (r_fill == 2'd2);
    assign o_valid = (r_fill != 2'd0);
    assign o_item  = r_buf[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr   <= 1'b0;
            r_rd   <= 1'b0;
            r_fill <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 2'd1;
                2'b01:   r_fill <= r_fill - 2'd1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

### rtl/rosel_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rosel_back
// Stores the window in a sample memory and, once it is full, finds the value
// at the requested rank by counting, for each candidate in turn, how many
// samples lie below it and how many lie at or below it.
// ----------------------------------------------------------------------------
module rosel_back #(
    parameter int unsigned WINDOW = 50
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  rosel_pkg::t_item                i_item,
    output logic                            o_pop,
    input  logic [rosel_pkg::RANK_W-1:0]    i_rank,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rosel_pkg::SAMPLE_W-1:0]  o_m_tdata
);
    import rosel_pkg::*;

    localparam int unsigned AW   = $clog2(WINDOW);
    localparam int unsigned CW   = $clog2(WINDOW + 1);
    localparam int unsigned LAST = WINDOW - 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_LOAD   = 3'd1;
    localparam logic [2:0] ST_CAND   = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_DECIDE = 3'd5;

    logic [SAMPLE_W-1:0] r_mem [WINDOW];
    logic [SAMPLE_W-1:0] r_rd_data;
    logic [AW-1:0]       rd_addr;

    logic [2:0]          r_state;
    logic [2:0]          n_state;
    logic [AW-1:0]       r_wr;
    logic [AW-1:0]       r_i;
    logic [AW-1:0]       r_j;
    logic                r_pend;
    logic [SAMPLE_W-1:0] r_cand;
    logic [CW-1:0]       r_lt;
    logic [CW-1:0]       r_le;
    logic [CW-1:0]       rank_sat;
    logic                found;
    logic                slot_free;
    logic                r_out_valid;
    logic [SAMPLE_W-1:0] r_out_data;

    assign o_pop      = (r_state == ST_IDLE) && i_valid;
    assign slot_free  = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // A rank beyond the window reports the largest sample.
    always_comb begin
        if (int'(i_rank) > LAST) begin
            rank_sat = CW'(LAST);
        end else begin
            rank_sat = CW'(i_rank);
        end
    end

    // The candidate holds the rank when it is the value at that position.
    assign found = (r_lt <= rank_sat) && (rank_sat < r_le);

    always_comb begin
        rd_addr = r_j;
        if (r_state == ST_LOAD) begin
            rd_addr = r_i;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_mem[r_wr] <= i_item.sample;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (o_pop && i_item.last) begin
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD:  n_state = ST_CAND;
            ST_CAND:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_j == AW'(LAST)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (!found) begin
                    n_state = ST_LOAD;
                end else if (slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_wr        <= '0;
            r_i         <= '0;
            r_j         <= '0;
            r_pend      <= 1'b0;
            r_lt        <= '0;
            r_le        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= (r_state == ST_SCAN);
            if (o_pop) begin
                r_wr <= i_item.last ? '0 : r_wr + 1'b1;
                r_i  <= '0;
            end
            if (r_state == ST_CAND) begin
                r_j  <= '0;
                r_lt <= '0;
                r_le <= '0;
            end else begin
                if (r_state == ST_SCAN) begin
                    r_j <= r_j + 1'b1;
                end
                if (r_pend) begin
                    if (r_rd_data < r_cand) begin
                        r_lt <= r_lt + 1'b1;
                    end
                    if (r_rd_data <= r_cand) begin
                        r_le <= r_le + 1'b1;
                    end
                end
            end
            if (r_state == ST_DECIDE && !found) begin
                r_i <= r_i + 1'b1;
            end
            if (r_state == ST_DECIDE && found && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_CAND) begin
            r_cand <= r_rd_data;
        end
        if (r_state == ST_DECIDE && found && slot_free) begin
            r_out_data <= r_cand;
        end
    end

    // The last candidate of a window must always hold the rank.
    a_found_by_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE && r_i == AW'(LAST)) |-> found)
        else $error("no candidate matched the rank");

    // A candidate always counts itself among the samples at or below it.
    a_self_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DECIDE) |-> (r_le > r_lt))
        else $error("candidate counts inconsistent");

    // Selection only runs on a complete window.
    a_window_closed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_wr == '0))
        else $error("selection started on a partial window");

endmodule

### rtl/rank_order_select_top.sv
`timescale 1ns / 1ps
// Flow: each sample beat is registered into the two-entry queue; the closing sample of a window
// starts a search in the back, which loads, scans and decides one candidate at a time until one
// holds the rank. A held result stalls the back until it is taken.
// Rate: one sample beat a cycle while the back is storing; during a search the back takes no new
// sample and the queue fills, so the input stalls until the search is done. The search is set by
// the single sample memory read port.
// Reset: synchronous, active low; empties the window and sets the rank to 31.
// ----------------------------------------------------------------------------
// rank_order_select_top
// Rank-order filter over fixed windows of 16-bit capacitance samples.
// ----------------------------------------------------------------------------
module rank_order_select_top #(
    parameter int unsigned WINDOW = 50
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [rosel_pkg::SAMPLE_W-1:0]  i_s_tdata,   // [15:0] sample
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [rosel_pkg::SAMPLE_W-1:0]  o_m_tdata,   // [15:0] selected_value
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rosel_pkg::RANK_W-1:0]    i_cfg_data   // [5:0] rank_index
);
    import rosel_pkg::*;

    t_item             front_item;
    t_item             queue_item;
    logic              push;
    logic              full;
    logic              pop;
    logic              queue_valid;
    logic [RANK_W-1:0] rank;

    rosel_front #(.WINDOW(WINDOW)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_full      (full),
        .o_push      (push),
        .o_item      (front_item),
        .o_rank      (rank)
    );

    rosel_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    rosel_back #(.WINDOW(WINDOW)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (queue_valid),
        .i_item     (queue_item),
        .o_pop      (pop),
        .i_rank     (rank),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
